[rtl/hetl_pkg.sv]
package hetl_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_LOAD = 2'd2
    } t_status;

    localparam logic [31:0] HASH_MUL_A = 32'h9E3779B1;
    localparam logic [31:0] HASH_MUL_B = 32'h85EBCA77;
    localparam int DUP_MAX = 1023;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH_MUL,
        S_HASH_SUM,
        S_PROBE_RD,
        S_PROBE_WAIT,
        S_PROBE_CHK,
        S_NEXT_EDGE,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_SETUP,
        S_CLEAR,
        S_DONE,
        S_INIT
    } t_state;

endpackage

[rtl/hetl_if.sv]
interface hetl_req_if #(parameter int VB = 16);
    logic          valid;
    logic          ready;
    logic [1:0]    op;
    logic [VB-1:0] vert_a;
    logic [VB-1:0] vert_b;
    logic [VB-1:0] vert_c;
    logic [9:0]    query_index;
    modport source(output valid, op, vert_a, vert_b, vert_c, query_index, input ready);
    modport sink(input valid, op, vert_a, vert_b, vert_c, query_index, output ready);
endinterface

interface hetl_rsp_if #(parameter int VB = 16);
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [7:0]    face_index;
    logic [1:0]    dup_added;
    logic [VB-1:0] edge_from;
    logic [VB-1:0] edge_to;
    logic          twin_found;
    logic [9:0]    twin_index;
    logic [9:0]    next_index;
    logic [9:0]    prev_index;
    logic [9:0]    dup_total;
    modport source(output valid, status, face_index, dup_added, edge_from, edge_to,
                   twin_found, twin_index, next_index, prev_index, dup_total,
                   input ready);
    modport sink(input valid, status, face_index, dup_added, edge_from, edge_to,
                 twin_found, twin_index, next_index, prev_index, dup_total,
                 output ready);
endinterface

[rtl/hetl_front.sv]
module hetl_front #(
    parameter int VB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hetl_req_if.sink        i_req,
    output logic            o_valid,
    input  logic            i_pop,
    output logic [1:0]      o_op,
    output logic [VB-1:0]   o_va,
    output logic [VB-1:0]   o_vb,
    output logic [VB-1:0]   o_vc,
    output logic [9:0]      o_qidx
);
    import hetl_pkg::*;

    localparam int W = 2 + 3 * VB + 10;

    logic [W-1:0] r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push;

    assign i_req.ready = (r_cnt != 2'd2);
    assign push = i_req.valid && i_req.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign {o_op, o_va, o_vb, o_vc, o_qidx} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {i_req.op, i_req.vert_a, i_req.vert_b, i_req.vert_c,
                          i_req.query_index};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule

[rtl/hetl_back.sv]
module hetl_back #(
    parameter int VB = 16,
    parameter int MF = 256,
    parameter int TS = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_pop,
    input  logic [1:0]    i_op,
    input  logic [VB-1:0] i_va,
    input  logic [VB-1:0] i_vb,
    input  logic [VB-1:0] i_vc,
    input  logic [9:0]    i_qidx,
    hetl_rsp_if.source    o_rsp
);
    import hetl_pkg::*;

    localparam int SB = (TS > 1) ? $clog2(TS) : 1;
    localparam int FB = (MF > 1) ? $clog2(MF) : 1;
    localparam int CB = $clog2(MF + 1);
    localparam int EB = $clog2(3 * MF + 1) + 1;

    t_state r_st, n_st;

    logic [3*VB-1:0] r_fmem [MF];
    logic [2*VB-1:0] r_kmem [TS];
    logic [EB-1:0]   r_emem [TS];
    logic            r_vmem [TS];

    logic [CB-1:0]   r_fcnt;
    logic [9:0]      r_dup;
    logic [VB-1:0]   r_v [3];
    logic [1:0]      r_k;
    logic [1:0]      r_dups;
    logic [VB-1:0]   r_from, r_to;
    logic [31:0]     r_pa, r_pb;
    logic [SB-1:0]   r_slot;
    logic [SB:0]     r_probes;
    logic [2*VB-1:0] r_krd;
    logic [EB-1:0]   r_erd;
    logic            r_vrd;
    logic [3*VB-1:0] r_frd;
    logic [FB-1:0]   r_qf;
    logic [1:0]      r_qk;
    logic [EB-1:0]   r_qbase;
    logic            r_qmode;
    logic [SB:0]     r_clr;

    logic            r_ov;
    logic [1:0]      r_status;
    logic [7:0]      r_fidx;
    logic [1:0]      r_dadd;
    logic [VB-1:0]   r_efrom, r_eto;
    logic            r_tf;
    logic [9:0]      r_ti, r_ni, r_pi;

    logic [SB-1:0]   probe_rd_addr;
    logic            key_hit;
    logic [EB-1:0]   cur_edge;
    logic [1:0]      k1;
    logic [10:0]     dsum;
    logic [20:0]     q_mul;
    logic [9:0]      q_div;
    logic [9:0]      q_rem3;

    assign o_rsp.valid      = r_ov;
    assign o_rsp.status     = r_status;
    assign o_rsp.face_index = r_fidx;
    assign o_rsp.dup_added  = r_dadd;
    assign o_rsp.edge_from  = r_efrom;
    assign o_rsp.edge_to    = r_eto;
    assign o_rsp.twin_found = r_tf;
    assign o_rsp.twin_index = r_ti;
    assign o_rsp.next_index = r_ni;
    assign o_rsp.prev_index = r_pi;
    assign o_rsp.dup_total  = r_dup;

    assign key_hit  = (r_krd == {r_from, r_to});
    assign cur_edge = EB'(r_fcnt) * EB'(3) + EB'(r_k);
    assign k1 = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
    assign dsum = 11'(r_dup) + 11'(r_dups);
    assign probe_rd_addr = r_slot;

    // divide by three through a reciprocal multiply, exact over ten bits
    assign q_mul  = 21'(i_qidx) * 21'(683);
    assign q_div  = q_mul[20:11];
    assign q_rem3 = i_qidx - (q_div + q_div + q_div);

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_valid && !r_ov) begin
                    o_pop = 1'b1;
                    priority case (i_op)
                        OP_ADD:   n_st = (32'(r_fcnt) >= 32'(MF)) ? S_DONE : S_HASH_MUL;
                        OP_QUERY: n_st = (32'(i_qidx) >= 32'(r_fcnt) * 3) ? S_DONE : S_Q_RD;
                        OP_CLEAR: n_st = S_CLEAR;
                        default:  n_st = S_DONE;
                    endcase
                end
            end
            S_HASH_MUL:   n_st = S_HASH_SUM;
            S_HASH_SUM:   n_st = S_PROBE_RD;
            S_PROBE_RD:   n_st = S_PROBE_WAIT;
            S_PROBE_WAIT: n_st = S_PROBE_CHK;
            S_PROBE_CHK: begin
                if (!r_vrd || key_hit || 32'(r_probes) + 1 >= 32'(TS)) begin
                    n_st = r_qmode ? S_DONE : S_NEXT_EDGE;
                end else begin
                    n_st = S_PROBE_RD;
                end
            end
            S_NEXT_EDGE:  n_st = (r_k == 2'd2) ? S_DONE : S_HASH_MUL;
            S_Q_RD:       n_st = S_Q_WAIT;
            S_Q_WAIT:     n_st = S_Q_SETUP;
            S_Q_SETUP:    n_st = S_HASH_MUL;
            S_CLEAR:      n_st = (32'(r_clr) >= 32'(TS - 1)) ? S_DONE : S_CLEAR;
            S_INIT:       n_st = (32'(r_clr) >= 32'(TS - 1)) ? S_IDLE : S_INIT;
            S_DONE:       n_st = S_IDLE;
            default:      n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_INIT;
        else          r_st <= n_st;
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_krd <= r_kmem[probe_rd_addr];
        r_erd <= r_emem[probe_rd_addr];
        r_vrd <= r_vmem[probe_rd_addr];
        r_frd <= r_fmem[r_qf];
        if (r_st == S_HASH_MUL && !r_qmode && r_k == 2'd0) begin
            r_fmem[r_fcnt[FB-1:0]] <= {r_v[0], r_v[1], r_v[2]};
        end
        if (r_st == S_PROBE_CHK && !r_qmode && !r_vrd) begin
            r_kmem[r_slot] <= {r_from, r_to};
            r_emem[r_slot] <= cur_edge;
        end
        // slot valid bits cleared one per cycle
        if (r_st == S_INIT || r_st == S_CLEAR) begin
            r_vmem[r_clr[SB-1:0]] <= 1'b0;
        end else if (r_st == S_PROBE_CHK && !r_qmode && !r_vrd) begin
            r_vmem[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_v[0]  <= i_va;
                r_v[1]  <= i_vb;
                r_v[2]  <= i_vc;
                r_k     <= 2'd0;
                r_dups  <= 2'd0;
                r_qmode <= (i_op == OP_QUERY);
                r_from  <= i_va;
                r_to    <= i_vb;
                r_qf    <= FB'(q_div);
                r_qk    <= q_rem3[1:0];
                r_qbase <= EB'(i_qidx - q_rem3);
            end
            S_HASH_MUL: begin
                r_pa <= 32'(r_from) * HASH_MUL_A;
                r_pb <= 32'(r_to) * HASH_MUL_B;
            end
            S_HASH_SUM: begin
                r_slot   <= SB'((r_pa + r_pb) % 32'(TS));
                r_probes <= '0;
            end
            S_PROBE_CHK: begin
                if (!r_vrd || key_hit) begin
                    if (r_vrd && !r_qmode) r_dups <= r_dups + 2'd1;
                end
                r_slot   <= (32'(r_slot) + 1 >= 32'(TS)) ? '0 : r_slot + SB'(1);
                r_probes <= r_probes + 1'b1;
            end
            S_NEXT_EDGE: begin
                r_k    <= k1;
                r_from <= r_v[k1];
                r_to   <= (k1 == 2'd2) ? r_v[0] : r_v[k1 + 2'd1];
            end
            S_Q_SETUP: begin
                r_k    <= r_qk;
                // looking up the reversed edge
                unique case (r_qk)
                    2'd0:    begin r_to <= r_frd[3*VB-1 -: VB]; r_from <= r_frd[2*VB-1 -: VB]; end
                    2'd1:    begin r_to <= r_frd[2*VB-1 -: VB]; r_from <= r_frd[VB-1:0]; end
                    default: begin r_to <= r_frd[VB-1:0]; r_from <= r_frd[3*VB-1 -: VB]; end
                endcase
            end
            default: ;
        endcase
    end

    // control state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt <= '0;
            r_dup  <= '0;
            r_ov   <= 1'b0;
            r_clr  <= '0;
        end else begin
            if (r_ov && o_rsp.ready) r_ov <= 1'b0;
            if (r_st == S_IDLE && n_st != S_IDLE) begin
                r_status <= ST_OK;
                r_fidx   <= '0;
                r_dadd   <= '0;
                r_efrom  <= '0;
                r_eto    <= '0;
                r_tf     <= 1'b0;
                r_ti     <= '0;
                r_ni     <= '0;
                r_pi     <= '0;
                if (i_op == OP_ADD && n_st == S_DONE) r_status <= ST_FULL;
                if (i_op == OP_QUERY && n_st == S_DONE) r_status <= ST_NOT_LOAD;
            end
            if (r_st == S_PROBE_CHK && r_qmode && r_vrd && key_hit) begin
                r_tf <= 1'b1;
                r_ti <= 10'(r_erd);
            end
            if (r_st == S_Q_SETUP) begin
                r_fidx  <= 8'(r_qf);
                unique case (r_qk)
                    2'd0:    begin r_efrom <= r_frd[3*VB-1 -: VB]; r_eto <= r_frd[2*VB-1 -: VB]; end
                    2'd1:    begin r_efrom <= r_frd[2*VB-1 -: VB]; r_eto <= r_frd[VB-1:0]; end
                    default: begin r_efrom <= r_frd[VB-1:0]; r_eto <= r_frd[3*VB-1 -: VB]; end
                endcase
                r_ni <= 10'(r_qbase + EB'((r_qk == 2'd2) ? 2'd0 : r_qk + 2'd1));
                r_pi <= 10'(r_qbase + EB'((r_qk == 2'd0) ? 2'd2 : r_qk - 2'd1));
            end
            if (r_st == S_NEXT_EDGE && r_k == 2'd2) begin
                r_fidx <= 8'(r_fcnt);
                r_dadd <= r_dups;
                r_fcnt <= r_fcnt + CB'(1);
                r_dup  <= (dsum > 11'(DUP_MAX)) ? 10'(DUP_MAX) : dsum[9:0];
            end
            if (r_st == S_CLEAR) begin
                r_fcnt <= '0;
                r_dup  <= '0;
            end
            if (r_st == S_DONE) r_ov <= 1'b1;
            if (r_st == S_INIT || r_st == S_CLEAR) r_clr <= r_clr + (SB+1)'(1);
            else                                   r_clr <= '0;
        end
    end
endmodule

[rtl/half_edge_twin_linker.sv]
// add: hashes and probes each edge of the new face; query: probes the reversed edge
// clear: one slot valid bit cleared per cycle
// throughput: one request at a time, the next starts once the result is taken
// each probe steps through address, registered read, compare and write
// reset: synchronous active low, clears face and duplicate counts, then a
// pass over every slot clears the slot valid bits before the first request
module half_edge_twin_linker #(
    parameter int MAX_FACES   = 256,
    parameter int VERTEX_BITS = 16,
    parameter int TABLE_SLOTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hetl_req_if.sink  i_req,
    hetl_rsp_if.source o_rsp
);
    import hetl_pkg::*;

    logic                   q_valid, q_pop;
    logic [1:0]             q_op;
    logic [VERTEX_BITS-1:0] q_va, q_vb, q_vc;
    logic [9:0]             q_idx;

    hetl_front #(.VB(VERTEX_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req),
        .o_valid(q_valid), .i_pop(q_pop), .o_op(q_op),
        .o_va(q_va), .o_vb(q_vb), .o_vc(q_vc), .o_qidx(q_idx)
    );

    hetl_back #(.VB(VERTEX_BITS), .MF(MAX_FACES), .TS(TABLE_SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_pop(q_pop),
        .i_op(q_op), .i_va(q_va), .i_vb(q_vb), .i_vc(q_vc), .i_qidx(q_idx),
        .o_rsp(o_rsp)
    );
endmodule

[rtl/hetl_checker.sv]
module hetl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_status,
    input logic [1:0] i_rsp_dup_added,
    input logic [9:0] i_rsp_dup_total
);
    import hetl_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid) else $error("response dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_status <= ST_NOT_LOAD) else $error("bad status");
    a_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_dup_added == 2'd0)
        else $error("dup on error");
    a_dupmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_dup_added != 2'd3 || i_rsp_dup_total != 10'd0)
        else $error("dup total inconsistent");
endmodule

bind half_edge_twin_linker hetl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready),
    .i_rsp_status(o_rsp.status), .i_rsp_dup_added(o_rsp.dup_added),
    .i_rsp_dup_total(o_rsp.dup_total)
);

[tb/sv/half_edge_twin_linker_tb.sv]
module half_edge_twin_linker_tb;
    import hetl_pkg::*;

    localparam int NFACES  = 256;
    localparam int NSLOTS  = 1024;
    localparam int LIMIT   = 4000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  face_index;
        logic [1:0]  dup_added;
        logic [15:0] edge_from;
        logic [15:0] edge_to;
        logic        twin_found;
        logic [9:0]  twin_index;
        logic [9:0]  next_index;
        logic [9:0]  prev_index;
        logic [9:0]  dup_total;
    } t_reply;

    typedef struct {
        t_op         op;
        logic [15:0] va;
        logic [15:0] vb;
        logic [15:0] vc;
        logic [9:0]  qi;
        bit          typed;
        t_reply      reply;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    hetl_req_if #(.VB(16)) req_if ();
    hetl_rsp_if #(.VB(16)) rsp_if ();

    half_edge_twin_linker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // mirror of the mesh state
    logic [15:0] mesh_vert [NFACES][3];
    int          mesh_faces;
    bit          link_valid [NSLOTS];
    logic [31:0] link_key [NSLOTS];
    logic [9:0]  link_edge [NSLOTS];
    int          mesh_dups;

    t_reply      reply_queue [$];
    int          mismatches;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    function automatic int edge_slot(logic [15:0] from, logic [15:0] to);
        logic [31:0] h;
        h = {16'd0, from} * HASH_MUL_A + {16'd0, to} * HASH_MUL_B;
        return h % NSLOTS;
    endfunction

    function automatic int link_insert(logic [15:0] from, logic [15:0] to, int hedge);
        int s;
        s = edge_slot(from, to);
        for (int p = 0; p < NSLOTS; p++) begin
            if (!link_valid[s]) begin
                link_valid[s] = 1;
                link_key[s]   = {from, to};
                link_edge[s]  = hedge[9:0];
                return 0;
            end
            if (link_key[s] == {from, to}) return 1;
            s = (s + 1) % NSLOTS;
        end
        return 0;
    endfunction

    function automatic t_reply mesh_apply(t_op op, logic [15:0] va, logic [15:0] vb,
                                          logic [15:0] vc, logic [9:0] qi);
        t_reply r;
        logic [15:0] v [3];
        int f, k, s, dups;
        r = '0;
        case (op)
            OP_ADD: begin
                if (mesh_faces >= NFACES) begin
                    r.status = ST_FULL;
                end else begin
                    f = mesh_faces;
                    v[0] = va; v[1] = vb; v[2] = vc;
                    dups = 0;
                    for (k = 0; k < 3; k++) begin
                        mesh_vert[f][k] = v[k];
                        dups += link_insert(v[k], v[(k + 1) % 3], 3 * f + k);
                    end
                    mesh_dups += dups;
                    if (mesh_dups > DUP_MAX) mesh_dups = DUP_MAX;
                    mesh_faces = f + 1;
                    r.face_index = f[7:0];
                    r.dup_added  = dups[1:0];
                end
            end
            OP_QUERY: begin
                if (qi >= 3 * mesh_faces) begin
                    r.status = ST_NOT_LOAD;
                end else begin
                    f = qi / 3;
                    k = qi % 3;
                    r.face_index = f[7:0];
                    r.edge_from  = mesh_vert[f][k];
                    r.edge_to    = mesh_vert[f][(k + 1) % 3];
                    s = edge_slot(r.edge_to, r.edge_from);
                    for (int p = 0; p < NSLOTS; p++) begin
                        if (!link_valid[s]) break;
                        if (link_key[s] == {r.edge_to, r.edge_from}) begin
                            r.twin_found = 1;
                            r.twin_index = link_edge[s];
                            break;
                        end
                        s = (s + 1) % NSLOTS;
                    end
                    r.next_index = 10'(3 * f + (k + 1) % 3);
                    r.prev_index = 10'(3 * f + (k + 2) % 3);
                end
            end
            OP_CLEAR: begin
                mesh_faces = 0;
                mesh_dups  = 0;
                foreach (link_valid[i]) link_valid[i] = 0;
            end
            default: ;
        endcase
        r.dup_total = mesh_dups[9:0];
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // response side
    always @(posedge i_clk) begin
        t_reply got, want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.status, rsp_if.face_index, rsp_if.dup_added, rsp_if.edge_from,
                       rsp_if.edge_to, rsp_if.twin_found, rsp_if.twin_index,
                       rsp_if.next_index, rsp_if.prev_index, rsp_if.dup_total};
                if (reply_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected reply %h", got);
                end else begin
                    want = reply_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("reply mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(t_op op, logic [15:0] va, logic [15:0] vb, logic [15:0] vc,
                                logic [9:0] qi, bit typed, t_reply typed_reply);
        t_reply want;
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= op;
        req_if.vert_a      <= va;
        req_if.vert_b      <= vb;
        req_if.vert_c      <= vc;
        req_if.query_index <= qi;
        want = mesh_apply(op, va, vb, vc, qi);
        if (typed && want !== typed_reply) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees with predictor %p", typed_reply);
        end
        reply_queue.push_back(want);
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic random_request();
        int pick;
        logic [15:0] va, vb, vc;
        pick = $urandom_range(99);
        va = (pick % 2) ? 16'($urandom_range(12)) : 16'($urandom);
        vb = 16'($urandom_range(12));
        vc = ($urandom_range(9) == 0) ? va : 16'($urandom_range(12));
        if (pick < 55)
            send_request(OP_ADD, va, vb, vc, 10'($urandom), 0, '0);
        else if (pick < 93)
            send_request(OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                         (pick < 85 && mesh_faces > 0) ?
                             10'($urandom_range(3 * mesh_faces - 1)) : 10'($urandom),
                         0, '0);
        else if (pick < 97)
            send_request(OP_NOP, va, vb, vc, 10'($urandom), 0, '0);
        else
            send_request(OP_CLEAR, va, vb, vc, 10'($urandom), 0, '0);
    endtask

    t_row dir_rows [$];

    initial begin
        cycle_count   = 0;
        mismatches    = 0;
        mesh_faces    = 0;
        mesh_dups     = 0;
        foreach (link_valid[i]) link_valid[i] = 0;
        send_idle_pct = 19;
        recv_idle_pct = 46;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.op          = OP_NOP;
        req_if.vert_a      = '0;
        req_if.vert_b      = '0;
        req_if.vert_c      = '0;
        req_if.query_index = '0;
        rsp_if.ready       = 1'b0;

        // query after reset, extremes, twins, degenerate, nop, clear
        dir_rows = '{
            '{OP_QUERY, 0, 0, 0, 0, 1, '{ST_NOT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{OP_ADD, 0, 16'hFFFF, 1, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{OP_ADD, 16'hFFFF, 0, 2, 0, 0, '0},
            '{OP_QUERY, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 16'hFFFF, 1, 3, 1, 2, 0}},
            '{OP_QUERY, 0, 0, 0, 5, 0, '0},
            '{OP_QUERY, 0, 0, 0, 6, 1, '{ST_NOT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{OP_ADD, 0, 16'hFFFF, 1, 0, 1, '{ST_OK, 2, 3, 0, 0, 0, 0, 0, 0, 3}},
            '{OP_ADD, 7, 7, 7, 0, 0, '0},
            '{OP_QUERY, 0, 0, 0, 10, 0, '0},
            '{OP_QUERY, 0, 0, 0, 11, 0, '0},
            '{OP_NOP, 16'hAAAA, 16'h5555, 16'hFFFF, 10'h3FF, 1,
              '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 5}},
            '{OP_QUERY, 0, 0, 0, 10'h3FF, 0, '0},
            '{OP_ADD, 16'h5555, 16'hAAAA, 16'h8000, 0, 0, '0},
            '{OP_QUERY, 0, 0, 0, 13, 0, '0},
            '{OP_CLEAR, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{OP_QUERY, 0, 0, 0, 0, 1, '{ST_NOT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0}},
            '{OP_ADD, 1, 2, 3, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0}}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].va, dir_rows[i].vb, dir_rows[i].vc,
                         dir_rows[i].qi, dir_rows[i].typed, dir_rows[i].reply);

        // fill the face store to hit the full status
        while (mesh_faces < NFACES)
            send_request(OP_ADD, 16'($urandom_range(40)), 16'($urandom_range(40)),
                         16'($urandom), 0, 0, '0);
        send_request(OP_ADD, 1, 2, 3, 0, 1, '{ST_FULL, 0, 0, 0, 0, 0, 0, 0, 0,
                     10'(mesh_dups)});
        send_request(OP_QUERY, 0, 0, 0, 10'd767, 0, '0);
        send_request(OP_CLEAR, 0, 0, 0, 0, 0, '0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
            recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 19 : 0;
            repeat (170) random_request();
        end
        req_if.valid <= 1'b0;

        while (reply_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && reply_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/hetl_pkg.sv
rtl/hetl_if.sv
rtl/hetl_front.sv
rtl/hetl_back.sv
rtl/half_edge_twin_linker.sv
rtl/hetl_checker.sv
tb/sv/half_edge_twin_linker_tb.sv
